@@ rtl/ptc_pkg.sv @@
// Package for the presence table with codes: item types, operation codes,
// entry layout and sizing constants. No dependencies.
package ptc_pkg;

  localparam int unsigned Entries = 1024;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned CountW  = 11;
  localparam int unsigned TotalW  = 64;
  localparam int unsigned OpW     = 3;
  // Generation tag stored with each entry; tag zero marks an empty entry.
  localparam int unsigned EpochW  = 8;

  localparam logic [OpW-1:0] OpInsert = 3'd0;
  localparam logic [OpW-1:0] OpRemove = 3'd1;
  localparam logic [OpW-1:0] OpClear  = 3'd2;
  localparam logic [OpW-1:0] OpCount  = 3'd3;
  localparam logic [OpW-1:0] OpQuery  = 3'd4;

  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = {EpochW{1'b1}};
  localparam logic [AddrW-1:0]  AddrLast   = AddrW'(Entries - 1);

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [IdxW-1:0]         entry_index;
    logic signed [CodeW-1:0] code_value;
  } in_item_t;

  typedef struct packed {
    logic signed [CodeW-1:0]  reply_value;
    logic signed [TotalW-1:0] running_total;
    logic [CountW-1:0]        occupancy;
  } out_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [EpochW-1:0] tag;
  } entry_t;

  // Decisions of the execute step that the table controller carries out.
  typedef struct packed {
    logic write_entry;  // write the addressed entry back
    logic set_valid;    // written entry becomes valid (insert) or empty (remove)
    logic clear_all;    // advance the generation tag, or sweep when it runs out
  } exec_ctl_t;

  typedef enum logic [2:0] {
    StSweep = 3'b001,
    StIdle  = 3'b010,
    StExec  = 3'b100
  } state_e;

endpackage

@@ rtl/presence_table_with_codes_core.sv @@
// Top level of the presence table with codes: entry memory, generation tags,
// sweep sequencer and output register. Depends on ptc_pkg and ptc_exec.
//
// Usage:
// Items arrive on in_item_i under in_valid_i / in_stall_o and each gives
// exactly one result on out_item_o under out_valid_o / out_stall_i. An item
// is taken at a clock edge where valid is high and stall is low.
// An accepted item reads its entry from the synchronous table memory at the
// accepting edge; in the update step that follows, the entry is updated,
// written back and the result is loaded into the output register, which
// raises out_valid_o. The block takes no new item until that update step is
// done, as each item makes a single read-then-write pass over the table
// memory. A clear-all normally takes effect at once by advancing an 8-bit
// generation tag; once every 255 clears the tag space runs out and a sweep
// writes every entry empty, which holds off input until all 1024 entries are
// written. After reset the same sweep runs once before the first item is
// taken. When the receiver stalls, the result waits in the output register;
// the next item is still accepted and read, and waits in its update step
// until the output register is free.
module presence_table_with_codes_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptc_pkg::out_item_t out_item_o
);

  ptc_pkg::state_e state_q, state_d;

  // Table memory: each entry holds its code and the generation tag of the
  // last insert. An entry is valid only when its tag equals the current one.
  ptc_pkg::entry_t mem [ptc_pkg::Entries];
  ptc_pkg::entry_t rdata_q;

  logic [ptc_pkg::AddrW-1:0]  sweep_q, sweep_d;
  logic [ptc_pkg::EpochW-1:0] epoch_q, epoch_d;
  logic [ptc_pkg::CountW-1:0] count_q, count_d;
  logic [ptc_pkg::TotalW-1:0] total_q, total_d;

  // Operation held between the read and the update cycle.
  logic [ptc_pkg::OpW-1:0]   op_q;
  logic [ptc_pkg::AddrW-1:0] addr_q;
  logic                      in_range_q;
  logic [ptc_pkg::CodeW-1:0] code_q;

  logic                out_valid_q, out_valid_d;
  ptc_pkg::out_item_t  out_item_q;

  logic                       in_accept;
  logic                       out_free;
  logic                       exec_fire;
  logic                       hit;
  ptc_pkg::exec_ctl_t         ctl;
  logic [ptc_pkg::CodeW-1:0]  reply;
  logic [ptc_pkg::CountW-1:0] exec_count;
  logic [ptc_pkg::TotalW-1:0] exec_total;

  logic                       mem_we;
  logic [ptc_pkg::AddrW-1:0]  mem_waddr;
  ptc_pkg::entry_t            mem_wdata;

  assign in_stall_o = (state_q != ptc_pkg::StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_fire  = (state_q == ptc_pkg::StExec) && out_free;
  assign hit        = (rdata_q.tag == epoch_q);

  ptc_exec u_exec (
    .op_i          (op_q),
    .in_range_i    (in_range_q),
    .hit_i         (hit),
    .stored_code_i (rdata_q.code),
    .count_i       (count_q),
    .total_i       (total_q),
    .ctl_o         (ctl),
    .reply_o       (reply),
    .count_o       (exec_count),
    .total_o       (exec_total)
  );

  // Write port: the sweep empties entries, the update step writes back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (state_q == ptc_pkg::StSweep) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
    end else if (exec_fire && ctl.write_entry) begin
      mem_we = 1'b1;
      if (ctl.set_valid) begin
        mem_wdata.code = code_q;
        mem_wdata.tag  = epoch_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rdata_q <= mem[ptc_pkg::AddrW'(in_item_i.entry_index)];
    end
  end

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    epoch_d     = epoch_q;
    count_d     = count_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ptc_pkg::StSweep: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == ptc_pkg::AddrLast) begin
          sweep_d = '0;
          epoch_d = ptc_pkg::EpochFirst;
          state_d = ptc_pkg::StIdle;
        end
      end
      ptc_pkg::StIdle: begin
        if (in_accept) begin
          state_d = ptc_pkg::StExec;
        end
      end
      ptc_pkg::StExec: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          count_d     = exec_count;
          total_d     = exec_total;
          state_d     = ptc_pkg::StIdle;
          if (ctl.clear_all) begin
            // Out of fresh tags: empty every entry before reusing them.
            if (epoch_q == ptc_pkg::EpochLast) begin
              state_d = ptc_pkg::StSweep;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ptc_pkg::StSweep;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptc_pkg::StSweep;
      sweep_q     <= '0;
      epoch_q     <= ptc_pkg::EpochFirst;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= in_item_i.operation;
      addr_q     <= ptc_pkg::AddrW'(in_item_i.entry_index);
      in_range_q <= (32'(in_item_i.entry_index) < 32'(ptc_pkg::Entries));
      code_q     <= in_item_i.code_value;
    end
    if (exec_fire) begin
      out_item_q.reply_value   <= reply;
      out_item_q.running_total <= exec_total;
      out_item_q.occupancy     <= exec_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/ptc_exec.sv @@
// Execute step of the presence table: decodes one operation against the
// entry read from the table and the occupancy and total registers.
// Depends on ptc_pkg.
module ptc_exec (
  input  logic [ptc_pkg::OpW-1:0]    op_i,
  input  logic                       in_range_i,
  input  logic                       hit_i,
  input  logic [ptc_pkg::CodeW-1:0]  stored_code_i,
  input  logic [ptc_pkg::CountW-1:0] count_i,
  input  logic [ptc_pkg::TotalW-1:0] total_i,
  output ptc_pkg::exec_ctl_t         ctl_o,
  output logic [ptc_pkg::CodeW-1:0]  reply_o,
  output logic [ptc_pkg::CountW-1:0] count_o,
  output logic [ptc_pkg::TotalW-1:0] total_o
);

  logic add_reply;

  always_comb begin
    ctl_o     = '0;
    reply_o   = '0;
    count_o   = count_i;
    add_reply = 1'b0;
    unique case (op_i)
      ptc_pkg::OpInsert: begin
        if (in_range_i) begin
          ctl_o.write_entry = 1'b1;
          ctl_o.set_valid   = 1'b1;
          if (!hit_i) begin
            count_o = count_i + 1'b1;
          end
        end
      end
      ptc_pkg::OpRemove: begin
        if (in_range_i && hit_i) begin
          ctl_o.write_entry = 1'b1;
          count_o           = count_i - 1'b1;
        end
      end
      ptc_pkg::OpClear: begin
        ctl_o.clear_all = 1'b1;
        count_o         = '0;
      end
      ptc_pkg::OpCount: begin
        reply_o   = ptc_pkg::CodeW'(count_i);
        add_reply = 1'b1;
      end
      ptc_pkg::OpQuery: begin
        reply_o   = (in_range_i && hit_i) ? stored_code_i : '1;
        add_reply = 1'b1;
      end
      default: begin
        reply_o = '0;
      end
    endcase
  end

  // Replies enter the total sign-extended; a count is never negative.
  assign total_o = add_reply
                 ? total_i + {{(ptc_pkg::TotalW - ptc_pkg::CodeW){reply_o[ptc_pkg::CodeW-1]}},
                              reply_o}
                 : total_i;

endmodule

@@ bench/presence_table_with_codes_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for presence_table_with_codes_core: directed and random operation items
// checked against a predictor of the table. Depends on ptc_pkg and the core.
module presence_table_with_codes_core_test;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ptc_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ptc_pkg::out_item_t out_item_o;

  presence_table_with_codes_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Predicted table contents. A code is only read back for a valid entry, so
  // the code of a removed or cleared entry never matters.
  bit                         valid_map [ptc_pkg::Entries];
  logic [ptc_pkg::CodeW-1:0]  code_map  [ptc_pkg::Entries];
  logic [ptc_pkg::CountW-1:0] live_count;
  logic [ptc_pkg::TotalW-1:0] sum_total;

  // Results still owed by the block, oldest first.
  ptc_pkg::out_item_t pending_results [$];

  int unsigned              mismatches;
  int unsigned              send_gap_pct;
  int unsigned              recv_stall_pct;
  logic [ptc_pkg::IdxW-1:0] hot_base;

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one operation to the predicted table and returns the result the
  // block should give for it. The running total is the 64-bit sum of every
  // count and query reply, with query replies sign extended.
  function automatic ptc_pkg::out_item_t table_apply(input ptc_pkg::in_item_t item);
    ptc_pkg::out_item_t        res;
    logic [ptc_pkg::CodeW-1:0] reply;
    reply = '0;
    case (item.operation)
      ptc_pkg::OpInsert: begin
        // Overwriting a valid entry leaves the count alone.
        if (!valid_map[item.entry_index]) begin
          valid_map[item.entry_index] = 1'b1;
          live_count = live_count + 1'b1;
        end
        code_map[item.entry_index] = item.code_value;
      end
      ptc_pkg::OpRemove: begin
        // Removing an entry that is not valid changes nothing.
        if (valid_map[item.entry_index]) begin
          valid_map[item.entry_index] = 1'b0;
          live_count = live_count - 1'b1;
        end
      end
      ptc_pkg::OpClear: begin
        foreach (valid_map[k]) valid_map[k] = 1'b0;
        live_count = '0;
      end
      ptc_pkg::OpCount: begin
        reply = ptc_pkg::CodeW'(live_count);
        sum_total = sum_total + ptc_pkg::TotalW'(live_count);
      end
      ptc_pkg::OpQuery: begin
        reply = valid_map[item.entry_index] ? code_map[item.entry_index] : '1;
        sum_total = sum_total
                  + {{(ptc_pkg::TotalW-ptc_pkg::CodeW){reply[ptc_pkg::CodeW-1]}}, reply};
      end
      default: begin
        // The spare operation codes leave the state alone and reply zero.
      end
    endcase
    res.reply_value   = reply;
    res.running_total = sum_total;
    res.occupancy     = live_count;
    return res;
  endfunction

  // Drives one item at the falling edge after an optional random gap, holds it
  // until the block takes it, and records the result it must produce. Valid is
  // left high so that back-to-back items need no second assignment in a step.
  task automatic send_item(input ptc_pkg::in_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(table_apply(item));
  endtask

  task automatic issue(input logic [ptc_pkg::OpW-1:0] op,
                       input logic [ptc_pkg::IdxW-1:0] idx,
                       input logic [ptc_pkg::CodeW-1:0] code);
    ptc_pkg::in_item_t item;
    item.operation   = op;
    item.entry_index = idx;
    item.code_value  = code;
    send_item(item);
  endtask

  // Drops valid and waits for every owed result to arrive.
  task automatic wait_drained;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Half of the indexes land in a small window that moves now and then, so that
  // removes and queries often find valid entries.
  function automatic logic [ptc_pkg::IdxW-1:0] pick_index();
    if ($urandom_range(19) == 0) hot_base = ptc_pkg::IdxW'($urandom());
    if ($urandom_range(1) == 1) return ptc_pkg::IdxW'($urandom());
    return hot_base + ptc_pkg::IdxW'($urandom_range(31));
  endfunction

  task automatic flag_mismatch(input string what, input logic [ptc_pkg::TotalW-1:0] want,
                               input logic [ptc_pkg::TotalW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [ptc_pkg::TotalW-1:0] want,
                             input logic [ptc_pkg::TotalW-1:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  // Result checker: every result taken from the block is compared with the
  // oldest prediction.
  always @(posedge clk_i) begin : result_check
    ptc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_item_o.running_total);
      end else begin
        want = pending_results.pop_front();
        check_field("reply_value", ptc_pkg::TotalW'(want.reply_value),
                    ptc_pkg::TotalW'(out_item_o.reply_value));
        check_field("running_total", want.running_total, out_item_o.running_total);
        check_field("occupancy", ptc_pkg::TotalW'(want.occupancy),
                    ptc_pkg::TotalW'(out_item_o.occupancy));
      end
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Field extremes, every operation and the corner cases: a query of an empty
  // entry, overwriting a valid entry, removing an empty entry, the spare
  // operation codes, and entries dropped by a clear.
  task automatic test_directed;
    int unsigned s;
    issue(ptc_pkg::OpQuery, '0, '0);
    issue(ptc_pkg::OpCount, '1, '1);
    issue(ptc_pkg::OpInsert, '0, 32'h7FFF_FFFF);
    issue(ptc_pkg::OpInsert, '1, 32'h8000_0000);
    issue(ptc_pkg::OpInsert, 10'h155, 32'hFFFF_FFFF);
    issue(ptc_pkg::OpInsert, 10'h2AA, 32'h0000_0000);
    issue(ptc_pkg::OpQuery, '0, '0);
    issue(ptc_pkg::OpQuery, '1, '0);
    issue(ptc_pkg::OpQuery, 10'h155, '0);
    issue(ptc_pkg::OpQuery, 10'h2AA, '0);
    issue(ptc_pkg::OpCount, '0, '0);
    issue(ptc_pkg::OpInsert, '0, 32'h1234_5678);
    issue(ptc_pkg::OpQuery, '0, '0);
    issue(ptc_pkg::OpCount, '0, '0);
    issue(ptc_pkg::OpRemove, 10'd5, '0);
    issue(ptc_pkg::OpRemove, '1, '0);
    issue(ptc_pkg::OpQuery, '1, '0);
    issue(ptc_pkg::OpCount, '0, '0);
    for (s = 1; s <= 3; s++) begin
      issue(ptc_pkg::OpQuery + ptc_pkg::OpW'(s), ptc_pkg::IdxW'($urandom()), $urandom());
    end
    issue(ptc_pkg::OpClear, '0, '0);
    issue(ptc_pkg::OpCount, '0, '0);
    issue(ptc_pkg::OpQuery, '0, '0);
    issue(ptc_pkg::OpInsert, '0, 32'd42);
    issue(ptc_pkg::OpQuery, '0, '0);
  endtask

  // Mostly inserts, removes and queries around the moving window, with counts,
  // some clears and a few spare codes.
  task automatic test_random_mix(input int unsigned n);
    int unsigned             k;
    int unsigned             pick;
    logic [ptc_pkg::OpW-1:0] op;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) op = ptc_pkg::OpInsert;
      else if (pick < 50) op = ptc_pkg::OpRemove;
      else if (pick < 78) op = ptc_pkg::OpQuery;
      else if (pick < 89) op = ptc_pkg::OpCount;
      else if (pick < 96) op = ptc_pkg::OpClear;
      else op = ptc_pkg::OpQuery + ptc_pkg::OpW'($urandom_range(3, 1));
      issue(op, pick_index(), $urandom());
    end
  endtask

  // Fills every entry in a shuffled order so that the occupancy reaches the
  // table size, then works on the full table and clears it.
  task automatic test_full_table;
    logic [ptc_pkg::IdxW-1:0] order [ptc_pkg::Entries];
    logic [ptc_pkg::IdxW-1:0] swap;
    int unsigned              k;
    int unsigned              j;
    for (k = 0; k < ptc_pkg::Entries; k++) order[k] = ptc_pkg::IdxW'(k);
    for (k = ptc_pkg::Entries - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      swap     = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    for (k = 0; k < ptc_pkg::Entries; k++) begin
      issue(ptc_pkg::OpInsert, order[k], $urandom());
      if (k % 128 == 127) issue(ptc_pkg::OpCount, ptc_pkg::IdxW'($urandom()), $urandom());
    end
    repeat (8) issue(ptc_pkg::OpQuery, ptc_pkg::IdxW'($urandom()), $urandom());
    issue(ptc_pkg::OpInsert, ptc_pkg::IdxW'($urandom()), $urandom());
    issue(ptc_pkg::OpCount, '0, '0);
    repeat (4) issue(ptc_pkg::OpRemove, ptc_pkg::IdxW'($urandom()), $urandom());
    issue(ptc_pkg::OpCount, '0, '0);
    issue(ptc_pkg::OpClear, '0, '0);
    issue(ptc_pkg::OpCount, '0, '0);
  endtask

  // More clears than the generation tag can count, so that at least one clear
  // falls back to the long sweep; inserts before and after the clears check
  // that the sweep hides old entries and keeps new ones.
  task automatic test_clear_wraparound;
    int unsigned              k;
    logic [ptc_pkg::IdxW-1:0] idx;
    for (k = 0; k < 260; k++) begin
      idx = pick_index();
      if (k % 16 == 0) issue(ptc_pkg::OpInsert, idx, $urandom());
      issue(ptc_pkg::OpClear, idx, $urandom());
      if (k % 16 == 8) begin
        issue(ptc_pkg::OpInsert, idx, $urandom());
        issue(ptc_pkg::OpQuery, idx, $urandom());
      end
    end
    issue(ptc_pkg::OpCount, '0, '0);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    live_count     = '0;
    sum_total      = '0;
    mismatches     = 0;
    hot_base       = '0;
    send_gap_pct   = 26;
    recv_stall_pct = 54;
    foreach (valid_map[k]) valid_map[k] = 1'b0;
    foreach (code_map[k]) code_map[k] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The block runs its clearing sweep after reset; the first item simply
    // waits on the stall.
    test_directed();
    test_random_mix(24);

    // Let the block run dry once before the next phase.
    wait_drained();
    send_gap_pct   = 54;
    recv_stall_pct = 26;
    test_full_table();
    test_clear_wraparound();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_mix(24);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run including the sweeps.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
